@@ design/i2a_pkg.sv @@
// shared types, constants and helpers for the integer to ascii formatter
// used by i2a_bcd_cell and integer_to_ascii_formatter_core; no dependencies
package i2a_pkg;

    localparam int VALUE_W    = 32;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;   // decimal digits of a 32-bit magnitude
    localparam int HEX_DIGITS = 8;
    localparam int BIN_DIGITS = 32;
    localparam int REM_W      = 6;    // holds up to BIN_DIGITS
    localparam int CNT_W      = 5;    // counts VALUE_W shift steps
    localparam int CHAR_W     = 7;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;

    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_HEX = 2'd1;
    localparam logic [1:0] BASE_BIN = 2'd2;

    localparam logic [CHAR_W-1:0] CH_ZERO     = 7'h30;
    localparam logic [CHAR_W-1:0] CH_LETTER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CH_MINUS    = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_NEWLINE  = 7'h0A;

    // control word broadcast to every digit cell
    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift;
    } cell_ctrl_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] wide;
        begin
            wide = {3'b000, d};
            if (d < 4'd10)
            begin
                return CH_ZERO + wide;
            end
            else
            begin
                return CH_LETTER_A + wide - 7'd10;
            end
        end
    endfunction

endpackage

@@ design/i2a_bcd_cell.sv @@
// one decimal digit cell of the shift-and-add-3 converter chain
// depends on i2a_pkg for the control word and digit width
module i2a_bcd_cell
    import i2a_pkg::*;
(
    input  logic               clk,
    input  cell_ctrl_t         ctrl,
    input  logic               carry_in,    // bit shifted in from the lower cell
    input  logic [DIGIT_W-1:0] digit_in,    // lower cell digit, used when draining
    output logic               carry_out,
    output logic [DIGIT_W-1:0] digit
);

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adj;

    // add 3 before the shift when the digit would overflow past 9
    assign adj       = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign carry_out = adj[DIGIT_W-1];
    assign digit     = digit_reg;

    always_comb
    begin
        priority if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[DIGIT_W-2:0], carry_in};
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

@@ design/integer_to_ascii_formatter_core.sv @@
// Renders a signed 32-bit value as ASCII text, one character per output word,
// most significant first with leading zeros dropped, in decimal, upper-case
// hex or binary, with an optional trailing line feed marked by tlast. One
// item is handled at a time; s_tready is high only between items. Decimal
// emits a leading minus when negative, shifts the magnitude through the row
// of ten digit cells (one input bit per cycle), then walks ten digit
// positions; hex walks 8 and binary 32 digit positions, and a line feed
// follows when asked for. Digit positions advance only while the output
// register is free, so a stalled m_tready holds the item back.
// depends on i2a_pkg and i2a_bcd_cell
module integer_to_ascii_formatter_core
    import i2a_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] value, [32] add_newline, rest zero
    input  logic [1:0]            s_tuser,   // [1:0] base_code
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [6:0] char_out, [7] zero
    output logic                  m_tlast    // last_char
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SIGN  = 3'd1;
    localparam logic [2:0] ST_CONV  = 3'd2;
    localparam logic [2:0] ST_DIGIT = 3'd3;
    localparam logic [2:0] ST_NL    = 3'd4;

    logic [2:0]         state_reg,   state_next;
    logic [VALUE_W-1:0] mag_reg,     mag_next;
    logic [CNT_W-1:0]   cnt_reg,     cnt_next;
    logic [REM_W-1:0]   rem_reg,     rem_next;
    logic               started_reg, started_next;
    logic [1:0]         base_reg,    base_next;
    logic               nl_reg,      nl_next;
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  out_char_reg,  out_char_next;
    logic               out_last_reg,  out_last_next;

    logic [VALUE_W-1:0] in_value;
    logic               in_nl;
    logic [1:0]         in_base;
    logic               accept;
    logic               slot_free;
    logic [DIGIT_W-1:0] cur_digit;
    logic               show_digit;
    cell_ctrl_t         cell_ctrl;

    logic [DIGIT_W-1:0] cell_digit [NUM_DIGITS+1];
    logic               cell_carry [NUM_DIGITS+1];

    assign in_value  = s_tdata[VALUE_W-1:0];
    assign in_nl     = s_tdata[VALUE_W];
    assign in_base   = s_tuser;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tlast  = out_last_reg;

    // row of digit cells, lowest digit first
    assign cell_carry[0] = mag_reg[VALUE_W-1];
    assign cell_digit[0] = '0;

    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_cell
        i2a_bcd_cell u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl),
            .carry_in  (cell_carry[i]),
            .digit_in  (cell_digit[i]),
            .carry_out (cell_carry[i+1]),
            .digit     (cell_digit[i+1])
        );
    end

    always_comb
    begin
        unique case (base_reg)
            BASE_DEC: cur_digit = cell_digit[NUM_DIGITS];
            BASE_HEX: cur_digit = mag_reg[VALUE_W-1 -: DIGIT_W];
            default:  cur_digit = {3'b000, mag_reg[VALUE_W-1]};
        endcase
    end

    // the last position always shows, so zero prints one '0'
    assign show_digit = started_reg || (cur_digit != '0) || (rem_reg == REM_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        started_next   = started_reg;
        base_next      = base_reg;
        nl_next        = nl_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        cell_ctrl      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    base_next    = in_base;
                    nl_next      = in_nl;
                    started_next = 1'b0;
                    mag_next     = in_value;
                    unique case (in_base)
                        BASE_DEC:
                        begin
                            cell_ctrl.clear = 1'b1;
                            cnt_next        = CNT_W'(VALUE_W - 1);
                            if (in_value[VALUE_W-1])
                            begin
                                mag_next   = VALUE_W'(0) - in_value;
                                state_next = ST_SIGN;
                            end
                            else
                            begin
                                state_next = ST_CONV;
                            end
                        end
                        BASE_HEX:
                        begin
                            rem_next   = REM_W'(HEX_DIGITS);
                            state_next = ST_DIGIT;
                        end
                        BASE_BIN:
                        begin
                            rem_next   = REM_W'(BIN_DIGITS);
                            state_next = ST_DIGIT;
                        end
                        default:
                        begin
                            state_next = in_nl ? ST_NL : ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CH_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cell_ctrl.dabble = 1'b1;
                mag_next         = {mag_reg[VALUE_W-2:0], 1'b0};
                cnt_next         = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    rem_next   = REM_W'(NUM_DIGITS);
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (slot_free)
                begin
                    if (show_digit)
                    begin
                        started_next   = 1'b1;
                        out_valid_next = 1'b1;
                        out_char_next  = digit_to_ascii(cur_digit);
                        out_last_next  = (rem_reg == REM_W'(1)) && !nl_reg;
                    end
                    unique case (base_reg)
                        BASE_DEC: cell_ctrl.shift = 1'b1;
                        BASE_HEX: mag_next = {mag_reg[VALUE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                        default:  mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
                    endcase
                    rem_next = rem_reg - REM_W'(1);
                    if (rem_reg == REM_W'(1))
                    begin
                        state_next = nl_reg ? ST_NL : ST_IDLE;
                    end
                end
            end
            ST_NL:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CH_NEWLINE;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            started_reg   <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        cnt_reg      <= cnt_next;
        rem_reg      <= rem_next;
        base_reg     <= base_next;
        nl_reg       <= nl_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    // no word is produced while the cells convert
    a_conv_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) |=> !$rose(out_valid_reg))
        else $error("output word appeared during conversion");

    // a 32-bit magnitude never overflows ten decimal digits
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) |-> !cell_carry[NUM_DIGITS])
        else $error("digit chain overflow");

    // digit phase always has positions left
    a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGIT) |-> (rem_reg != '0))
        else $error("digit phase with no positions left");

    // line feed is always the final word of an item
    a_nl_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_char_reg == CH_NEWLINE)) |-> out_last_reg)
        else $error("line feed not marked last");

    // only decimal items use the cell row
    a_conv_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) |-> (base_reg == BASE_DEC))
        else $error("conversion entered for a non-decimal base");

endmodule
